// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL files that check their own logic.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent true implies consequent true in the same cycle.
`define ERP_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("erp assertion failed");

// Antecedent true implies consequent true in the next cycle.
`define ERP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("erp assertion failed");

// Expression must never be true.
`define ERP_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("erp assertion failed");

`endif

// ===== hw/rtl/erp_pkg.sv =====
// Shared types and constants of the edge replicate padder.
// No dependencies; the files that use it refer to it by scoped names.
package erp_pkg;

  localparam int MAX_DIM = 4096;
  localparam int MAX_PAD = 3;

  localparam int DIM_W   = 13;  // width of a dimension register
  localparam int CNT_W   = 12;  // source coordinate counters
  localparam int PAD_W   = 2;
  localparam int COORD_W = 13;  // padded image coordinates
  localparam int CHAN_W  = 8;
  localparam int IDX_W   = 3;   // index into the pad run, 0 .. 2*MAX_PAD
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_WIDTH  = 2'd2;

  // Controller to datapath
  typedef struct packed {
    logic load;  // latch a new source pixel and advance the frame counters
    logic step;  // write the next result into the output register
  } erp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic last;  // the position about to be written is the final one
  } erp_sts_t;

endpackage

// ===== hw/rtl/erp_if.sv =====
// Valid/ready channel interfaces for source pixels and padded results.
// Depends on erp_pkg for field widths.
interface erp_pix_if;
  logic                        valid;
  logic                        ready;
  logic [erp_pkg::CHAN_W-1:0]  red;
  logic [erp_pkg::CHAN_W-1:0]  green;
  logic [erp_pkg::CHAN_W-1:0]  blue;
  logic [erp_pkg::CHAN_W-1:0]  alpha;

  modport source (output valid, red, green, blue, alpha, input ready);
  modport sink   (input valid, red, green, blue, alpha, output ready);
endinterface

interface erp_res_if;
  logic                        valid;
  logic                        ready;
  logic [erp_pkg::COORD_W-1:0] out_x;
  logic [erp_pkg::COORD_W-1:0] out_y;
  logic [erp_pkg::CHAN_W-1:0]  out_red;
  logic [erp_pkg::CHAN_W-1:0]  out_green;
  logic [erp_pkg::CHAN_W-1:0]  out_blue;
  logic [erp_pkg::CHAN_W-1:0]  out_alpha;
  logic                        last_of_run;

  modport source (output valid, out_x, out_y, out_red, out_green, out_blue, out_alpha,
                  last_of_run, input ready);
  modport sink   (input valid, out_x, out_y, out_red, out_green, out_blue, out_alpha,
                  last_of_run, output ready);
endinterface

// ===== hw/rtl/erp_ctrl.sv =====
// Controller of the edge replicate padder: accept/emit state machine and output valid.
// Depends on erp_pkg for the command and status structs.
module erp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output erp_pkg::erp_cmd_t cmd,
  input  erp_pkg::erp_sts_t sts
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic state;
  logic state_next;
  logic out_valid_next;
  logic out_free;

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;
  assign cmd.load = in_valid && in_ready;
  assign cmd.step = (state == ST_EMIT) && out_free;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd.load) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (cmd.step && sts.last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.step) out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== hw/rtl/erp_datapath.sv =====
// Datapath of the edge replicate padder: config registers, frame counters,
// pad run indexes and the output payload register. Depends on erp_pkg.
module erp_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [erp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [erp_pkg::DIM_W-1:0]     cfg_data,
  input  erp_pkg::erp_cmd_t             cmd,
  output erp_pkg::erp_sts_t             sts,
  input  logic [erp_pkg::CHAN_W-1:0]    red,
  input  logic [erp_pkg::CHAN_W-1:0]    green,
  input  logic [erp_pkg::CHAN_W-1:0]    blue,
  input  logic [erp_pkg::CHAN_W-1:0]    alpha,
  output logic [erp_pkg::COORD_W-1:0]   out_x,
  output logic [erp_pkg::COORD_W-1:0]   out_y,
  output logic [erp_pkg::CHAN_W-1:0]    out_red,
  output logic [erp_pkg::CHAN_W-1:0]    out_green,
  output logic [erp_pkg::CHAN_W-1:0]    out_blue,
  output logic [erp_pkg::CHAN_W-1:0]    out_alpha,
  output logic                          last_of_run
);

  // Last valid coordinate for a raw dimension: zero acts as one, oversize clamps.
  function automatic logic [erp_pkg::CNT_W-1:0] dim_last(
    input logic [erp_pkg::DIM_W-1:0] raw
  );
    logic [erp_pkg::DIM_W-1:0] less;
    begin
      less = raw - erp_pkg::DIM_W'(1);
      if (raw == '0) dim_last = '0;
      else if (raw > erp_pkg::DIM_W'(erp_pkg::MAX_DIM))
        dim_last = erp_pkg::CNT_W'(erp_pkg::MAX_DIM - 1);
      else dim_last = less[erp_pkg::CNT_W-1:0];
    end
  endfunction

  // Padded coordinate of entry k of the run for source coordinate c.
  function automatic logic [erp_pkg::COORD_W-1:0] run_coord(
    input logic [erp_pkg::CNT_W-1:0] c,
    input logic [erp_pkg::PAD_W-1:0] p,
    input logic [erp_pkg::IDX_W-1:0] k,
    input logic [erp_pkg::IDX_W-1:0] top
  );
    logic [erp_pkg::IDX_W-1:0] off;
    begin
      off = k - top;
      if (k < top) run_coord = erp_pkg::COORD_W'(k);
      else run_coord = erp_pkg::COORD_W'(c) + erp_pkg::COORD_W'(p) + erp_pkg::COORD_W'(off);
    end
  endfunction

  logic [erp_pkg::DIM_W-1:0]  src_width;
  logic [erp_pkg::DIM_W-1:0]  src_height;
  logic [erp_pkg::PAD_W-1:0]  pad_width;
  logic [erp_pkg::CNT_W-1:0]  column_count;
  logic [erp_pkg::CNT_W-1:0]  row_count;

  logic [erp_pkg::CNT_W-1:0]  cur_x;
  logic [erp_pkg::CNT_W-1:0]  cur_y;
  logic [erp_pkg::CHAN_W-1:0] pix_r, pix_g, pix_b, pix_a;
  logic [erp_pkg::IDX_W-1:0]  row_idx;
  logic [erp_pkg::IDX_W-1:0]  col_idx;

  logic [erp_pkg::CNT_W-1:0]  w_last, h_last;
  logic [erp_pkg::IDX_W-1:0]  pad_ext;
  logic [erp_pkg::IDX_W-1:0]  col_top, col_bot, row_top, row_bot;
  logic [erp_pkg::IDX_W-1:0]  col_end, row_end;
  logic                       col_done, row_done;
  logic                       cfg_hit;

  assign w_last  = dim_last(src_width);
  assign h_last  = dim_last(src_height);
  assign pad_ext = erp_pkg::IDX_W'(pad_width);

  assign col_top = (cur_x == '0)     ? pad_ext : '0;
  assign col_bot = (cur_x == w_last) ? pad_ext : '0;
  assign row_top = (cur_y == '0)     ? pad_ext : '0;
  assign row_bot = (cur_y == h_last) ? pad_ext : '0;
  assign col_end = col_top + col_bot;
  assign row_end = row_top + row_bot;

  assign col_done = (col_idx == col_end);
  assign row_done = (row_idx == row_end);
  assign sts.last = col_done && row_done;

  assign cfg_hit = cfg_we && (cfg_index == erp_pkg::REG_SRC_WIDTH ||
                              cfg_index == erp_pkg::REG_SRC_HEIGHT ||
                              cfg_index == erp_pkg::REG_PAD_WIDTH);

  // Config registers and frame counters
  always_ff @(posedge clk) begin
    if (rst) begin
      src_width    <= erp_pkg::DIM_W'(1);
      src_height   <= erp_pkg::DIM_W'(1);
      pad_width    <= erp_pkg::PAD_W'(1);
      column_count <= '0;
      row_count    <= '0;
    end else if (cfg_hit) begin
      case (cfg_index)
        erp_pkg::REG_SRC_WIDTH:  src_width  <= cfg_data;
        erp_pkg::REG_SRC_HEIGHT: src_height <= cfg_data;
        erp_pkg::REG_PAD_WIDTH:  pad_width  <= cfg_data[erp_pkg::PAD_W-1:0];
        default: ;
      endcase
      column_count <= '0;
      row_count    <= '0;
    end else if (cmd.load) begin
      if (column_count == w_last) begin
        column_count <= '0;
        row_count    <= (row_count == h_last) ? '0 : row_count + erp_pkg::CNT_W'(1);
      end else begin
        column_count <= column_count + erp_pkg::CNT_W'(1);
      end
    end
  end

  // Pixel latch and run indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      row_idx <= '0;
      col_idx <= '0;
    end else if (cmd.load) begin
      row_idx <= '0;
      col_idx <= '0;
    end else if (cmd.step) begin
      if (col_done) begin
        col_idx <= '0;
        row_idx <= row_idx + erp_pkg::IDX_W'(1);
      end else begin
        col_idx <= col_idx + erp_pkg::IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_x <= column_count;
      cur_y <= row_count;
      pix_r <= red;
      pix_g <= green;
      pix_b <= blue;
      pix_a <= alpha;
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      out_x       <= run_coord(cur_x, pad_width, col_idx, col_top);
      out_y       <= run_coord(cur_y, pad_width, row_idx, row_top);
      out_red     <= pix_r;
      out_green   <= pix_g;
      out_blue    <= pix_b;
      out_alpha   <= pix_a;
      last_of_run <= sts.last;
    end
  end

endmodule

// ===== hw/rtl/edge_replicate_padder.sv =====
// Channel   Dir  Payload                                              Role
// pix       in   red green blue alpha                                 source pixel, raster order
// res       out  out_x out_y out_red out_green out_blue out_alpha     padded position and color
//                last_of_run
// cfg_*     in   cfg_we cfg_index cfg_data                            register writes
//
// Each pixel is accepted, then yields r * c results, where r and c are 1 + pad
// for each border it touches (pad rows above/below, pad columns left/right).
// An interior pixel yields a single result.
// Take the next request once a pixel's final result is registered; it drains meanwhile.
// Synchronous active-high reset clears the counters, the state and the output valid,
// and sets width, height and pad to one. A stalled res.ready holds the output register and pauses the emit sequence.
//
// Top level of the edge replicate padder. Depends on erp_pkg, erp_if, erp_ctrl,
// erp_datapath and assert_macros.svh.
`include "assert_macros.svh"

module edge_replicate_padder (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [erp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [erp_pkg::DIM_W-1:0]     cfg_data,
  erp_pix_if.sink                       pix,
  erp_res_if.source                     res
);

  erp_pkg::erp_cmd_t cmd;
  erp_pkg::erp_sts_t sts;

  // Sequencing: accept one pixel, then walk its run of positions.
  erp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pix.valid),
    .in_ready  (pix.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Counters, coordinate generation and output register.
  erp_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cmd         (cmd),
    .sts         (sts),
    .red         (pix.red),
    .green       (pix.green),
    .blue        (pix.blue),
    .alpha       (pix.alpha),
    .out_x       (res.out_x),
    .out_y       (res.out_y),
    .out_red     (res.out_red),
    .out_green   (res.out_green),
    .out_blue    (res.out_blue),
    .out_alpha   (res.out_alpha),
    .last_of_run (res.last_of_run)
  );

  // Once the final result of a pixel is loaded, the next request may enter.
  `ERP_ASSERT_NEXT(a_last_frees_input, cmd.step && sts.last, pix.ready)
  // An accepted pixel blocks further requests until its run is emitted.
  `ERP_ASSERT_NEXT(a_accept_blocks, pix.valid && pix.ready, !pix.ready)
  // Never overwrite a result the sink has not taken.
  `ERP_ASSERT_NEVER(a_no_overwrite, cmd.step && res.valid && !res.ready)
  // Loading a pixel and emitting a result never coincide.
  `ERP_ASSERT_NEVER(a_load_step_excl, cmd.load && cmd.step)

endmodule
